FILE: src/iaql_pkg.sv
// Shared types and constants for the indexed array list.
// Holds the list capacity, the action codes, field widths and the per-cell control word.
// No dependencies.
package iaql_pkg;

	// Number of entries the list can hold; the result fields are sized for it.
	localparam int CAPACITY = 32;

	// Field widths of the request and result words.
	localparam int ACT_W  = 3;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int FPOS_W = 5;
	localparam int CNT_W  = 6;

	// Request actions; the remaining codes are rejected.
	typedef enum logic [ACT_W-1:0] {
		ACT_GET    = 3'd0,
		ACT_LOCATE = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic capture; // latch the compare against the incoming search value
		logic ins;     // open a gap at the position and write the new value
		logic del;     // close the gap at the position
	} cell_ctrl_t;

endpackage

FILE: src/iaql_cell.sv
// One storage cell of the list chain: holds a single entry and its match flag.
// Shifts to or from its neighbours on insert and delete. Depends on iaql_pkg.
module iaql_cell #(
	parameter int PW = 6
) (
	input  logic                      clk,
	input  iaql_pkg::cell_ctrl_t      ctrl,
	input  logic [PW-1:0]             idx,
	input  logic [PW-1:0]             pos,
	input  logic [iaql_pkg::VAL_W-1:0] cmp_value,
	input  logic [iaql_pkg::VAL_W-1:0] wr_value,
	input  logic [iaql_pkg::VAL_W-1:0] left,
	input  logic [iaql_pkg::VAL_W-1:0] right,
	output logic [iaql_pkg::VAL_W-1:0] entry,
	output logic                      eq
);
	import iaql_pkg::*;

	logic [VAL_W-1:0] entry_q;
	logic             eq_q;
	logic             at;
	logic             above;

	// Where this cell sits relative to the addressed position.
	assign at    = (idx == pos);
	assign above = (idx > pos);

	// Entry update and match flag.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			eq_q <= (entry_q == cmp_value);
		end
		if (ctrl.ins) begin
			if (at) begin
				entry_q <= wr_value;
			end else if (above) begin
				entry_q <= left;
			end
		end else if (ctrl.del && (at || above)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign eq    = eq_q;

endmodule

FILE: src/indexed_array_list.sv
// Indexed array list: an ordered list of signed words held in a chain of cells.
// A request word is held until it commits; its result word is then registered.
// A new request is accepted only once the held one commits. The cells register
// their compare on accept; the shift, read and locate encoder resolve on commit.
// Reset clears the length and the handshake state; entries are not cleared.
module indexed_array_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // action[2:0], position[8:3], item_value[40:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // status[0], read_value[32:1], found[33],
	                                    // found_position[38:34], count[44:39]
);
	import iaql_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int PW = (FW > POS_W) ? FW : POS_W;

	// Request fields from the input word.
	logic [ACT_W-1:0] in_action;
	logic [POS_W-1:0] in_pos;
	logic [VAL_W-1:0] in_value;
	logic             accept;

	assign in_action = s_axis_tdata[2:0];
	assign in_pos    = s_axis_tdata[8:3];
	assign in_value  = s_axis_tdata[40:9];
	assign accept    = s_axis_tvalid && s_axis_tready;

	// Request held for the commit cycle.
	logic             busy_s1;
	action_t          act_s1;
	logic [POS_W-1:0] pos_s1;
	logic [VAL_W-1:0] val_s1;
	logic [FW-1:0]    fill_q;
	logic             out_valid_q;
	logic             commit;

	assign s_axis_tready = !busy_s1;
	assign commit        = busy_s1 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= action_t'(in_action);
			pos_s1 <= in_pos;
			val_s1 <= in_value;
		end
	end

	// Cell chain.
	cell_ctrl_t       ctrl;
	logic [PW-1:0]    pos_ext;
	logic [PW-1:0]    fill_ext;
	logic [VAL_W-1:0] cell_entry [CAPACITY];
	logic [CAPACITY-1:0] cell_eq;
	logic             range_ok;
	logic             ins_ok;

	assign pos_ext  = PW'(pos_s1);
	assign fill_ext = PW'(fill_q);
	assign range_ok = (pos_ext < fill_ext);
	assign ins_ok   = (fill_ext < PW'(CAPACITY)) && (pos_ext <= fill_ext);

	assign ctrl.capture = accept;
	assign ctrl.ins     = commit && (act_s1 == ACT_INSERT) && ins_ok;
	assign ctrl.del     = commit && (act_s1 == ACT_DELETE) && range_ok;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_w;
		logic [VAL_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = val_s1;
		end else begin : g_mid
			assign left_w = cell_entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_entry[i];
		end else begin : g_inner
			assign right_w = cell_entry[i+1];
		end

		iaql_cell #(
			.PW(PW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.idx      (PW'(i)),
			.pos      (pos_ext),
			.cmp_value(in_value),
			.wr_value (val_s1),
			.left     (left_w),
			.right    (right_w),
			.entry    (cell_entry[i]),
			.eq       (cell_eq[i])
		);
	end

	// Read select and first-match encoder over the chain.
	logic [VAL_W-1:0] rd_sel;
	logic             loc_hit;
	logic [PW-1:0]    loc_idx;

	always_comb begin
		rd_sel  = '0;
		loc_hit = 1'b0;
		loc_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (PW'(i) == pos_ext) begin
				rd_sel = rd_sel | cell_entry[i];
			end
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_eq[i] && (PW'(i) < fill_ext)) begin
				loc_hit = 1'b1;
				loc_idx = PW'(i);
			end
		end
	end

	// Result and next length for the held request.
	logic             res_status;
	logic [VAL_W-1:0] res_read;
	logic             res_found;
	logic [PW-1:0]    res_fpos;
	logic [FW-1:0]    fill_next;

	always_comb begin
		res_status = 1'b0;
		res_read   = '0;
		res_found  = 1'b0;
		res_fpos   = '0;
		fill_next  = fill_q;
		case (act_s1)
			ACT_GET: begin
				if (range_ok) begin
					res_read = rd_sel;
				end else begin
					res_status = 1'b1;
				end
			end
			ACT_LOCATE: begin
				res_found = loc_hit;
				res_fpos  = loc_idx;
			end
			ACT_INSERT: begin
				if (ins_ok) begin
					fill_next = fill_q + FW'(1);
				end else begin
					res_status = 1'b1;
				end
			end
			ACT_DELETE: begin
				if (range_ok) begin
					res_read  = rd_sel;
					fill_next = fill_q - FW'(1);
				end else begin
					res_status = 1'b1;
				end
			end
			ACT_CLEAR: begin
				fill_next = '0;
			end
			default: begin
				res_status = 1'b1;
			end
		endcase
	end

	// Length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (commit) begin
			fill_q <= fill_next;
		end
	end

	// Output word register.
	logic              status_q;
	logic [VAL_W-1:0]  read_value_q;
	logic              found_q;
	logic [FPOS_W-1:0] found_position_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q         <= res_status;
			read_value_q     <= res_read;
			found_q          <= res_found;
			found_position_q <= res_fpos[FPOS_W-1:0];
			count_q          <= CNT_W'(fill_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, count_q, found_position_q, found_q, read_value_q, status_q};

	// The length never exceeds the capacity.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_ext <= PW'(CAPACITY))
		else $error("list length above capacity");

	// The length changes only when a request commits.
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> (fill_q == $past(fill_q)))
		else $error("list length changed without a commit");

	// A committed request always leaves a result word waiting.
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_axis_tvalid)
		else $error("commit did not present a result word");

	// A request is only accepted after the previous one has committed.
	a_one_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_s1 && !s_axis_tready))
		else $error("request accepted while another was held");

endmodule
